[rtl/bhist_pkg.sv]
// Shared constants, codes and types of the bucketed histogram.
package bhist_pkg;

   localparam int MAX_BOUNDS     = 7;              // boundaries that may be in use, 0..7
   localparam int NUM_BOUND_REGS = 7;              // boundary registers present
   localparam int NUM_BUCKETS    = NUM_BOUND_REGS + 1;
   localparam int RANK_W         = 3;              // bucket rank / bound count width
   localparam int VALUE_W        = 32;             // Q16.16 sample and boundary width
   localparam int COUNT_W        = 32;
   localparam int SUM_W          = 64;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 32;
   localparam int REQ_TDATA_W    = 32;
   localparam int RSP_FIELDS_W   = RANK_W + VALUE_W + COUNT_W + COUNT_W + SUM_W;
   localparam int RSP_TDATA_W    = ((RSP_FIELDS_W + 7) / 8) * 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BOUND_COUNT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_BOUNDARY_0  = CSR_IDX_W'(1);

   // request selector codes
   localparam logic FUNC_OBSERVE = 1'b0;
   localparam logic FUNC_READOUT = 1'b1;

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   // observe item leaving the input register
   typedef struct packed {
      logic                      valid;
      logic signed [VALUE_W-1:0] sample;
   } obs_type;

   // observe item with its bucket resolved, headed for the accumulators
   typedef struct packed {
      logic                      valid;
      logic [RANK_W-1:0]         bucket;
      logic signed [VALUE_W-1:0] sample;
   } upd_type;

endpackage

[rtl/bucketed_histogram.sv]
// Top level of the bucketed histogram: input register, register file and wiring.
//
// Bins signed Q16.16 samples into up to eight buckets set by up to seven
// boundary registers; a sample's bucket is the number of active boundaries
// less than or equal to it, so boundaries may be written in any order.
// Observe transfers (tuser = 0) are taken one per cycle while no read-out
// waits or streams: input register, bucket-select register (parallel
// compares), then the saturating accumulators, so an observe produces no
// result. A read-out transfer (tuser = 1) waits for the one accumulate still
// in flight, then streams bound_count + 1 results, one per cycle while
// rsp_tready is high, lowest bucket first; the last one carries tlast and
// tuser (no upper bound). The input is held off while a read-out streams.
// Boundary ranks are re-registered every cycle from the register file, so
// they follow it in the next cycle. Counts, the cumulative count and the sum
// saturate; tallies survive reconfiguration. Registers: index 0 bound_count
// (bits 2:0), indexes 1..7 boundary_0..boundary_6.
module bucketed_histogram
   import bhist_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [31:0] sample
   input  logic                   req_tuser,   // [0] func
   // result channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [2:0] bucket_rank, [34:3] upper_limit, [66:35] cumulative_count,
   // [98:67] total_count, [162:99] total_sum, [167:163] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tuser,   // [0] upper_infinite
   output logic                   rsp_tlast,   // last
   // configuration write port
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // register file
   logic [RANK_W-1:0]         bound_count_ff;
   logic signed [VALUE_W-1:0] bound_ff [NUM_BOUND_REGS];
   logic [RANK_W-1:0]         n_in_use;

   // input register
   logic                      in_valid_ff;
   logic                      in_func_ff;
   logic signed [VALUE_W-1:0] in_sample_ff;
   logic                      in_adv;
   logic                      in_load;

   obs_type                   obs;
   upd_type                   upd;
   logic                      rd_busy;
   logic                      rd_start;
   logic [COUNT_W-1:0]        tally [NUM_BUCKETS];
   logic [COUNT_W-1:0]        sample_total;
   logic signed [SUM_W-1:0]   value_total;

   always_ff @(posedge clock) begin
      if (reset) begin
         bound_count_ff <= '0;
         for (int i = 0; i < NUM_BOUND_REGS; i++) begin
            bound_ff[i] <= '0;
         end
      end else if (csr_we) begin
         if (csr_index == CSR_BOUND_COUNT) begin
            bound_count_ff <= csr_wdata[RANK_W-1:0];
         end else begin
            bound_ff[csr_index - CSR_BOUNDARY_0] <= csr_wdata[VALUE_W-1:0];
         end
      end
   end

   // clamp the count to the supported number of boundaries
   assign n_in_use = (bound_count_ff > RANK_W'(MAX_BOUNDS)) ? RANK_W'(MAX_BOUNDS)
                                                          : bound_count_ff;

   // An observe moves on every cycle unless a read-out is streaming; a
   // read-out starts only once the accumulators hold every earlier sample.
   assign in_adv   = in_valid_ff && !rd_busy && ((in_func_ff == FUNC_OBSERVE) || !upd.valid);
   assign rd_start = in_adv && (in_func_ff == FUNC_READOUT);
   assign req_tready = !in_valid_ff || in_adv;
   assign in_load  = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_load) begin
         in_valid_ff <= 1'b1;
      end else if (in_adv) begin
         in_valid_ff <= 1'b0;
      end
      if (in_load) begin
         in_func_ff   <= req_tuser;
         in_sample_ff <= req_tdata[VALUE_W-1:0];
      end
   end

   assign obs.valid  = in_adv && (in_func_ff == FUNC_OBSERVE);
   assign obs.sample = in_sample_ff;

   bhist_bucket_sel u_bucket_sel (
      .clock    (clock),
      .reset    (reset),
      .obs      (obs),
      .bound    (bound_ff),
      .n_in_use (n_in_use),
      .upd      (upd)
   );

   bhist_accum u_accum (
      .clock        (clock),
      .reset        (reset),
      .upd          (upd),
      .tally        (tally),
      .sample_total (sample_total),
      .value_total  (value_total)
   );

   bhist_readout u_readout (
      .clock        (clock),
      .reset        (reset),
      .start        (rd_start),
      .bound        (bound_ff),
      .n_in_use     (n_in_use),
      .tally        (tally),
      .sample_total (sample_total),
      .value_total  (value_total),
      .busy         (rd_busy),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast)
   );

   // no accumulate may land while a read-out streams its snapshot
   a_no_update_in_readout: assert property (@(posedge clock) disable iff (reset)
      rd_busy |-> !upd.valid)
      else $error("accumulator update during read-out");

   // a read-out only starts with the pipeline drained and the sequencer idle
   a_start_when_drained: assert property (@(posedge clock) disable iff (reset)
      rd_start |-> (!upd.valid && !rd_busy))
      else $error("read-out started with work in flight");

   // the unbounded bucket is exactly the final one
   a_last_is_infinite: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == rsp_tuser))
      else $error("last and upper_infinite disagree");

   // a started read-out always reaches the sequencer on the next edge
   a_start_sets_busy: assert property (@(posedge clock) disable iff (reset)
      rd_start |=> rd_busy)
      else $error("read-out start lost");

endmodule

[rtl/bhist_bucket_sel.sv]
// Bucket selection stage: compares a sample against the active boundaries.
module bhist_bucket_sel
   import bhist_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  obs_type                   obs,
   input  logic signed [VALUE_W-1:0] bound [NUM_BOUND_REGS],
   input  logic [RANK_W-1:0]         n_in_use,
   output upd_type                   upd
);

   upd_type                   upd_ff;
   upd_type                   upd_in;
   logic [NUM_BOUND_REGS-1:0] hit;

   always_comb begin
      for (int i = 0; i < NUM_BOUND_REGS; i++) begin
         hit[i] = (RANK_W'(i) < n_in_use) && (bound[i] <= obs.sample);
      end
      upd_in.valid  = obs.valid;
      upd_in.bucket = RANK_W'($countones(hit));
      upd_in.sample = obs.sample;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upd_ff.valid <= 1'b0;
      end else begin
         upd_ff.valid <= upd_in.valid;
      end
      upd_ff.bucket <= upd_in.bucket;
      upd_ff.sample <= upd_in.sample;
   end

   assign upd = upd_ff;

endmodule

[rtl/bhist_accum.sv]
// Saturating per-bucket tallies, total sample count and total sample sum.
module bhist_accum
   import bhist_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  upd_type                 upd,
   output logic [COUNT_W-1:0]      tally [NUM_BUCKETS],
   output logic [COUNT_W-1:0]      sample_total,
   output logic signed [SUM_W-1:0] value_total
);

   logic [COUNT_W-1:0]      tally_ff [NUM_BUCKETS];
   logic [COUNT_W-1:0]      tally_in [NUM_BUCKETS];
   logic [COUNT_W-1:0]      sample_total_ff;
   logic [COUNT_W-1:0]      sample_total_in;
   logic signed [SUM_W-1:0] value_total_ff;
   logic signed [SUM_W-1:0] value_total_in;
   logic [SUM_W:0]          sum_wide;

   always_comb begin
      for (int i = 0; i < NUM_BUCKETS; i++) begin
         tally_in[i] = tally_ff[i];
         if (upd.valid && (upd.bucket == RANK_W'(i)) && (tally_ff[i] != '1)) begin
            tally_in[i] = tally_ff[i] + COUNT_W'(1);
         end
      end

      sample_total_in = sample_total_ff;
      if (upd.valid && (sample_total_ff != '1)) begin
         sample_total_in = sample_total_ff + COUNT_W'(1);
      end

      // 65-bit sum; the top two bits disagree on overflow
      sum_wide = {value_total_ff[SUM_W-1], value_total_ff}
               + {{(SUM_W-VALUE_W+1){upd.sample[VALUE_W-1]}}, upd.sample};
      value_total_in = value_total_ff;
      if (upd.valid) begin
         if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            value_total_in = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
         end else begin
            value_total_in = sum_wide[SUM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BUCKETS; i++) begin
            tally_ff[i] <= '0;
         end
         sample_total_ff <= '0;
         value_total_ff  <= '0;
      end else begin
         tally_ff        <= tally_in;
         sample_total_ff <= sample_total_in;
         value_total_ff  <= value_total_in;
      end
   end

   assign tally        = tally_ff;
   assign sample_total = sample_total_ff;
   assign value_total  = value_total_ff;

endmodule

[rtl/bhist_readout.sv]
// Read-out sequencer: ranks boundaries and streams one result per bucket.
module bhist_readout
   import bhist_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [VALUE_W-1:0] bound [NUM_BOUND_REGS],
   input  logic [RANK_W-1:0]         n_in_use,
   input  logic [COUNT_W-1:0]        tally [NUM_BUCKETS],
   input  logic [COUNT_W-1:0]        sample_total,
   input  logic signed [SUM_W-1:0]   value_total,
   output logic                      busy,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                      rsp_tuser,
   output logic                      rsp_tlast
);

   logic [RANK_W-1:0]         rank_ff [NUM_BOUND_REGS];
   logic [RANK_W-1:0]         rank_in [NUM_BOUND_REGS];
   logic                      busy_ff;
   logic                      busy_in;
   logic [RANK_W-1:0]         k_ff;
   logic [RANK_W-1:0]         k_in;
   logic [COUNT_W-1:0]        cum_ff;
   logic [COUNT_W-1:0]        cum_in;
   logic                      valid_ff;
   logic                      valid_in;
   logic [RSP_TDATA_W-1:0]    tdata_ff;
   logic [RSP_TDATA_W-1:0]    tdata_in;
   logic                      tuser_ff;
   logic                      tuser_in;
   logic                      tlast_ff;
   logic                      tlast_in;
   logic                      load_ok;
   logic                      at_top;
   logic [NUM_BOUND_REGS-1:0] below;
   logic signed [VALUE_W-1:0] upper;
   logic [COUNT_W:0]          cum_wide;
   logic [COUNT_W-1:0]        cum_next;

   // rank of each boundary among those in use, ties by register number
   always_comb begin
      for (int i = 0; i < NUM_BOUND_REGS; i++) begin
         for (int j = 0; j < NUM_BOUND_REGS; j++) begin
            below[j] = (RANK_W'(j) < n_in_use)
                     && ((bound[j] < bound[i]) || ((bound[j] == bound[i]) && (j < i)));
         end
         rank_in[i] = RANK_W'($countones(below));
      end
   end

   always_comb begin
      load_ok = !valid_ff || rsp_tready;
      at_top  = (k_ff == n_in_use);

      upper = '0;
      for (int i = 0; i < NUM_BOUND_REGS; i++) begin
         if ((RANK_W'(i) < n_in_use) && (rank_ff[i] == k_ff)) begin
            upper = upper | bound[i];
         end
      end

      cum_wide = {1'b0, cum_ff} + {1'b0, tally[k_ff]};
      cum_next = cum_wide[COUNT_W] ? '1 : cum_wide[COUNT_W-1:0];

      busy_in  = busy_ff;
      k_in     = k_ff;
      cum_in   = cum_ff;
      valid_in = valid_ff;
      tdata_in = tdata_ff;
      tuser_in = tuser_ff;
      tlast_in = tlast_ff;

      if (start) begin
         busy_in = 1'b1;
         k_in    = '0;
         cum_in  = '0;
      end else if (busy_ff && load_ok) begin
         k_in     = k_ff + RANK_W'(1);
         cum_in   = cum_next;
         busy_in  = !at_top;
         valid_in = 1'b1;
         tdata_in = RSP_TDATA_W'({value_total, sample_total, cum_next, upper, k_ff});
         tuser_in = at_top;
         tlast_in = at_top;
      end

      if (!(busy_ff && !start && load_ok) && rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
      rank_ff  <= rank_in;
      k_ff     <= k_in;
      cum_ff   <= cum_in;
      tdata_ff <= tdata_in;
      tuser_ff <= tuser_in;
      tlast_ff <= tlast_in;
   end

   assign busy       = busy_ff;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = tdata_ff;
   assign rsp_tuser  = tuser_ff;
   assign rsp_tlast  = tlast_ff;

endmodule
